/* hdl/tcvp_pkg.sv */
// ----------------------------------------------------------------------------
// tcvp_pkg: shared types and constants of the text console value printer
// Payload structs, opcodes, character codes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package tcvp_pkg;

   // default screen geometry
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // cursor and field widths
   localparam int LINE_W = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int WORD_W = 16;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;

   // digit shift register: ten BCD digits, or a value left-aligned
   localparam int DIG_W  = 40;
   localparam int CNT_W  = 6;

   localparam logic [CNT_W-1:0] CNT_DEC_STEPS = 6'd32;
   localparam logic [CNT_W-1:0] CNT_DEC_DIGITS = 6'd10;
   localparam logic [CNT_W-1:0] CNT_HEX_DIGITS = 6'd8;
   localparam logic [CNT_W-1:0] CNT_BIN_DIGITS = 6'd32;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

   // opcodes
   localparam logic [2:0] OP_RAW  = 3'd0;
   localparam logic [2:0] OP_SDEC = 3'd1;
   localparam logic [2:0] OP_UDEC = 3'd2;
   localparam logic [2:0] OP_HEX  = 3'd3;
   localparam logic [2:0] OP_BIN  = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_B       = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 8'h37; // 'A' - 10

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] cell_address;
      logic [WORD_W-1:0] cell_word;
      logic              is_last;
   } rsp_type;

   // source of the character written into the output beat
   typedef enum logic [2:0] {
      SEL_RAW   = 3'd0,
      SEL_MINUS = 3'd1,
      SEL_ZERO  = 3'd2,
      SEL_TAG   = 3'd3,
      SEL_DIGIT = 3'd4
   } char_sel_type;

   typedef struct packed {
      logic         load;       // latch the accepted item
      logic         dabble;     // one binary-to-BCD step
      logic         set_dec;    // conversion done, ten digits to walk
      logic         shift;      // drop the top digit
      logic         emit;       // load a character into the output register
      char_sel_type char_sel;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a beat this cycle
      logic cnt_one;    // one step or digit left
      logic top_zero;   // top digit is zero
   } status_type;

   // hex digit to uppercase ASCII
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
      if (d < 4'd10) begin
         return CHAR_ZERO + {4'b0, d};
      end else begin
         return CHAR_LETTER_BASE + {4'b0, d};
      end
   endfunction

endpackage

/* hdl/tcvp_ctrl.sv */
// ----------------------------------------------------------------------------
// tcvp_ctrl: sequencer of the text console value printer
// Walks one item through raw output, or sign, prefix, conversion, zero skip
// and digit output, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module tcvp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcvp_pkg::req_type    req_data,
   input  tcvp_pkg::status_type status,
   output tcvp_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_RAW     = 8'b0000_0010,
      S_SIGN    = 8'b0000_0100,
      S_CONVERT = 8'b0000_1000,
      S_PREFIX0 = 8'b0001_0000,
      S_PREFIX1 = 8'b0010_0000,
      S_SKIP    = 8'b0100_0000,
      S_DIGIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // decide next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.char_sel = tcvp_pkg::SEL_RAW;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_data.opcode)
                  tcvp_pkg::OP_RAW: state_in = S_RAW;
                  tcvp_pkg::OP_SDEC: begin
                     state_in = req_data.value[31] ? S_SIGN : S_CONVERT;
                  end
                  tcvp_pkg::OP_UDEC: state_in = S_CONVERT;
                  tcvp_pkg::OP_HEX, tcvp_pkg::OP_BIN: state_in = S_PREFIX0;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RAW: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SIGN: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.char_sel = tcvp_pkg::SEL_MINUS;
               state_in     = S_CONVERT;
            end
         end
         S_CONVERT: begin
            cmd.dabble = 1'b1;
            if (status.cnt_one) begin
               cmd.set_dec = 1'b1;
               state_in    = S_SKIP;
            end
         end
         S_PREFIX0: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.char_sel = tcvp_pkg::SEL_ZERO;
               state_in     = S_PREFIX1;
            end
         end
         S_PREFIX1: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.char_sel = tcvp_pkg::SEL_TAG;
               state_in     = S_SKIP;
            end
         end
         S_SKIP: begin
            // drop leading zeros, always keep the last digit
            if (status.top_zero && !status.cnt_one) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.shift    = 1'b1;
               cmd.char_sel = tcvp_pkg::SEL_DIGIT;
               cmd.last     = status.cnt_one;
               if (status.cnt_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/tcvp_datapath.sv */
// ----------------------------------------------------------------------------
// tcvp_datapath: digit engine, cursor and output register
// Holds the digit shift register with its binary-to-BCD step, the cursor,
// the attribute register and the result beat.
// ----------------------------------------------------------------------------
module tcvp_datapath #(
   parameter int COLUMNS = tcvp_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcvp_pkg::ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcvp_pkg::req_type                 req_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcvp_pkg::ATTR_W-1:0]       csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tcvp_pkg::rsp_type                 rsp_data,
   input  tcvp_pkg::cmd_type                 cmd,
   output tcvp_pkg::status_type              status
);

   localparam int LW = tcvp_pkg::LINE_W;
   localparam int CW = tcvp_pkg::COL_W;
   localparam int DW = tcvp_pkg::DIG_W;
   localparam int PW = LW + CW;
   localparam logic [LW-1:0] LAST_LINE = LW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

   logic [DW-1:0]                   digits_ff, digits_in;
   logic [31:0]                     value_ff, value_in;
   logic [tcvp_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            bin_mode_ff, bin_mode_in;
   logic [tcvp_pkg::CHAR_W-1:0]     tag_ff, tag_in;
   logic [tcvp_pkg::CHAR_W-1:0]     raw_ff;
   logic [tcvp_pkg::ATTR_W-1:0]     attr_ff;
   logic [LW-1:0]                   line_ff, line_in;
   logic [CW-1:0]                   col_ff, col_in;
   logic                            rsp_valid_ff;
   tcvp_pkg::rsp_type               rsp_ff, rsp_in;

   logic [31:0]                     magnitude;
   logic [DW-1:0]                   adjusted;
   logic [3:0]                      top_digit;
   logic [tcvp_pkg::CHAR_W-1:0]     out_char;
   logic [LW-1:0]                   next_line;
   logic [PW-1:0]                   position;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // magnitude of a negative signed value
   assign magnitude = (req_data.opcode == tcvp_pkg::OP_SDEC && req_data.value[31])
                      ? (~req_data.value + 32'd1) : req_data.value;

   // add three to every BCD digit of five or more
   always_comb begin
      for (int i = 0; i < DW / 4; i++) begin
         adjusted[i*4 +: 4] = (digits_ff[i*4 +: 4] >= 4'd5)
                              ? digits_ff[i*4 +: 4] + 4'd3 : digits_ff[i*4 +: 4];
      end
   end

   assign top_digit = bin_mode_ff ? {3'b000, digits_ff[DW-1]} : digits_ff[DW-1 -: 4];

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.cnt_one  = (cnt_ff == tcvp_pkg::CNT_W'(1));
   assign status.top_zero = (top_digit == 4'd0);

   // digit engine next values
   always_comb begin
      digits_in   = digits_ff;
      value_in    = value_ff;
      cnt_in      = cnt_ff;
      bin_mode_in = bin_mode_ff;
      tag_in      = tag_ff;
      if (cmd.load) begin
         case (req_data.opcode)
            tcvp_pkg::OP_HEX: begin
               digits_in   = {req_data.value, 8'h00};
               cnt_in      = tcvp_pkg::CNT_HEX_DIGITS;
               bin_mode_in = 1'b0;
               tag_in      = tcvp_pkg::CHAR_X;
            end
            tcvp_pkg::OP_BIN: begin
               digits_in   = {req_data.value, 8'h00};
               cnt_in      = tcvp_pkg::CNT_BIN_DIGITS;
               bin_mode_in = 1'b1;
               tag_in      = tcvp_pkg::CHAR_B;
            end
            default: begin
               digits_in   = '0;
               value_in    = magnitude;
               cnt_in      = tcvp_pkg::CNT_DEC_STEPS;
               bin_mode_in = 1'b0;
            end
         endcase
      end else if (cmd.dabble) begin
         digits_in = {adjusted[DW-2:0], value_ff[31]};
         value_in  = {value_ff[30:0], 1'b0};
         cnt_in    = cmd.set_dec ? tcvp_pkg::CNT_DEC_DIGITS : cnt_ff - 1'b1;
      end else if (cmd.shift) begin
         digits_in = bin_mode_ff ? {digits_ff[DW-2:0], 1'b0} : {digits_ff[DW-5:0], 4'h0};
         cnt_in    = cnt_ff - 1'b1;
      end
   end

   // pick the character of this beat
   always_comb begin
      case (cmd.char_sel)
         tcvp_pkg::SEL_RAW:   out_char = raw_ff;
         tcvp_pkg::SEL_MINUS: out_char = tcvp_pkg::CHAR_MINUS;
         tcvp_pkg::SEL_ZERO:  out_char = tcvp_pkg::CHAR_ZERO;
         tcvp_pkg::SEL_TAG:   out_char = tag_ff;
         tcvp_pkg::SEL_DIGIT: out_char = tcvp_pkg::hex_char(top_digit);
         default:             out_char = raw_ff;
      endcase
   end

   assign next_line = (line_ff == LAST_LINE) ? '0 : line_ff + 1'b1;
   assign position  = PW'(line_ff) * PW'(COLUMNS) + PW'(col_ff);

   // build the result beat and advance the cursor
   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      rsp_in  = rsp_ff;
      if (cmd.emit) begin
         rsp_in.is_last = cmd.last;
         if (out_char == tcvp_pkg::CHAR_NEWLINE) begin
            rsp_in.write_enable = 1'b0;
            rsp_in.cell_address = '0;
            rsp_in.cell_word    = '0;
            line_in             = next_line;
            col_in              = '0;
         end else begin
            rsp_in.write_enable = 1'b1;
            rsp_in.cell_address = position[tcvp_pkg::ADDR_W-1:0];
            rsp_in.cell_word    = {attr_ff, out_char};
            if (col_ff == LAST_COL) begin
               col_in  = '0;
               line_in = next_line;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         col_ff       <= '0;
         attr_ff      <= tcvp_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_ff <= line_in;
         col_ff  <= col_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_data;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      value_ff    <= value_in;
      cnt_ff      <= cnt_in;
      bin_mode_ff <= bin_mode_in;
      tag_ff      <= tag_in;
      rsp_ff      <= rsp_in;
      if (cmd.load) begin
         raw_ff <= req_data.value[7:0];
      end
   end

endmodule

/* hdl/text_console_value_printer.sv */
// ----------------------------------------------------------------------------
// text_console_value_printer: number and character printer for a text screen
// Turns one request beat into a run of text-cell write beats at the cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries an opcode and a 32-bit value: raw character, signed or
//          unsigned decimal, 0x hex or 0b binary. One item is taken at a time;
//          req_ready is high only while no item is in progress.
//   rsp_*  carries one cell write per character, is_last marks the final beat
//          of an item. A newline beat has write_enable low and only moves the
//          cursor. Items with unused opcodes are taken and give no beats.
//   csr_*  writes the attribute byte; always ready.
// Timing: at most one character beat per cycle. A raw character gives one beat
//   after acceptance; hex and binary emit the 0x or 0b prefix beats, then drop
//   leading zeros, always keeping the last digit, and give one beat per printed
//   digit (binary of a full word: 34 beats). Decimal runs a binary-to-BCD shift
//   loop after the optional sign beat, then drops leading zeros and gives one
//   beat per digit. req_ready rises with the last beat.
// Reset clears the cursor to row 0, column 0 and the attribute to 15.
// A stalled receiver holds the output register; the sequencer waits at its
// next beat until the held beat is taken.
// ----------------------------------------------------------------------------
module text_console_value_printer #(
   parameter int COLUMNS = tcvp_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcvp_pkg::ROWS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tcvp_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tcvp_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tcvp_pkg::ATTR_W-1:0]  csr_data
);

   tcvp_pkg::cmd_type    cmd;
   tcvp_pkg::status_type status;

   // sequencer
   tcvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   // digit engine, cursor and output beat
   tcvp_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
